// File: src/assert_macros.svh
// Assertion macros used by the core RTL file of the longest-path block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/dlp_pkg.sv
// Package with field widths, register map and reset value of the longest-path block.
`default_nettype none

package dlp_pkg;

	// Payload field widths.
	localparam int unsigned VERTEX_W    = 7;
	localparam int unsigned PLEN_W      = 6;
	localparam int unsigned S_TDATA_W   = 16;
	localparam int unsigned M_TDATA_W   = 16;

	// Configuration port.
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	// Register index taken from paddr[2].
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Reset value of the vertex count register.
	localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

`default_nettype wire

// File: src/dag_longest_path_per_vertex_core.sv
// Longest path per vertex of a directed graph: edge loader, relaxation engine, result stream.
//
// Usage: edges arrive on the s_ channel, one item each; s_tdata holds edge_from and
// edge_to, s_tlast marks the final edge of a graph. Each edge is loaded in S_IDLE and
// S_EDGE_WR as a read-modify-write of one adjacency row; an edge with an endpoint of 0
// or above the vertex count is dropped. After the final edge the block runs n relaxation
// rounds (n = vertex_count clamped to 1..MAX_VERTICES). Each round visits every vertex u,
// reads its adjacency row and walks the n path lengths of the previous round through
// the length memory, one per cycle, as the length memory has a single read port.
// Results then leave on the m_ channel, vertex 1 first, each through S_EMIT_RD,
// S_EMIT_LD and S_EMIT_WAIT; the next result is loaded only once the current one has
// been accepted, and m_tlast marks the result for vertex n. No input is taken from
// the final edge until the last result has been accepted. A stall on m_tready simply
// holds the current result. After the last result the adjacency is cleared at once
// through per-row valid bits, so no clearing pass is needed, and the cycle flag is reset;
// the same holds after reset. The vertex count register sits at APB address 0; the user
// must write it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module dag_longest_path_per_vertex_core #(
	parameter int unsigned MAX_VERTICES = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Configuration port.
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [dlp_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire  [dlp_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [dlp_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready,
	// Edge input: tdata = {2'b0, edge_to[6:0], edge_from[6:0]}, tlast = last_edge.
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [dlp_pkg::S_TDATA_W-1:0]        s_tdata,
	input  wire                                  s_tlast,
	// Result output: tdata = {2'b0, cycle_seen, path_length[5:0], vertex[6:0]},
	// tlast = last_result.
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [dlp_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic                                 m_tlast
);

	`include "assert_macros.svh"

	localparam int unsigned VW = $clog2(MAX_VERTICES);
	localparam int unsigned LW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned LEN_DEPTH = 2 ** (VW + 1);
	localparam logic [dlp_pkg::VERTEX_W-1:0] MAX_N = dlp_pkg::VERTEX_W'(MAX_VERTICES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE_WR,
		S_ROW,
		S_WALK,
		S_DRAIN,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t state_q;

	logic [dlp_pkg::VERTEX_W-1:0] vertex_count_q;
	logic [dlp_pkg::VERTEX_W-1:0] n_eff;
	logic [VW-1:0]                n_m1;

	// Adjacency memory, one row per start vertex, and a valid bit per row.
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic                    adj_vld_rd_q;
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [VW-1:0]           adj_raddr;
	logic [MAX_VERTICES-1:0] row_cur;

	// Length memory, two banks for the previous and the current round.
	logic [LW-1:0] len_mem [LEN_DEPTH];
	logic [LW-1:0] len_rd_q;
	logic [VW:0]   len_raddr;

	// Loader registers.
	logic [VW-1:0] from_idx_q;
	logic [VW-1:0] to_idx_q;
	logic          last_q;

	// Relaxation counters and datapath.
	logic [VW-1:0] u_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] round_q;
	logic          bank_q;
	logic          vld_s1;
	logic [VW-1:0] v_s1;
	logic [LW-1:0] best_q;
	logic [LW-1:0] cur_val;
	logic [LW-1:0] cand;
	logic [LW-1:0] best_nxt;
	logic          cyc_q;

	// Input decode.
	logic [dlp_pkg::VERTEX_W-1:0] in_from;
	logic [dlp_pkg::VERTEX_W-1:0] in_to;
	logic                         in_ok;
	logic                         in_acc;

	// Result formatting.
	logic [VW-1:0]                cap_len;
	logic [dlp_pkg::VERTEX_W-1:0] out_vertex;

	// Effective vertex count, clamped to 1..MAX_VERTICES.
	always_comb begin
		if (vertex_count_q == '0) begin
			n_eff = dlp_pkg::VERTEX_W'(1);
		end else if (vertex_count_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = vertex_count_q;
		end
	end
	assign n_m1 = VW'(n_eff - dlp_pkg::VERTEX_W'(1));

	// Configuration register and read-back.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= dlp_pkg::VCOUNT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == dlp_pkg::REG_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[dlp_pkg::VERTEX_W-1:0];
		end
	end
	assign prdata = (paddr[2] == dlp_pkg::REG_VERTEX_COUNT)
		? dlp_pkg::APB_DATA_W'(vertex_count_q) : '0;

	// Edge decode and range check against the current count.
	assign in_from = s_tdata[dlp_pkg::VERTEX_W-1:0];
	assign in_to   = s_tdata[2*dlp_pkg::VERTEX_W-1:dlp_pkg::VERTEX_W];
	assign in_ok   = (in_from != '0) && (in_from <= n_eff) && (in_to != '0) && (in_to <= n_eff);
	assign s_tready = (state_q == S_IDLE);
	assign in_acc  = s_tvalid && s_tready;

	// Memory addresses: the loader reads the edge's row, the engine reads row u.
	assign adj_raddr = (state_q == S_IDLE) ? VW'(in_from - dlp_pkg::VERTEX_W'(1)) : u_q;
	assign len_raddr = (state_q == S_WALK) ? {bank_q, v_q} : {bank_q, u_q};

	// Adjacency memory: written by the loader, read every cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_EDGE_WR) begin
			adj_mem[from_idx_q] <= (adj_vld_rd_q ? adj_rd_q : '0)
				| (MAX_VERTICES'(1) << to_idx_q);
		end
		adj_rd_q     <= adj_mem[adj_raddr];
		adj_vld_rd_q <= row_valid_q[adj_raddr];
	end

	// Length memory: the new round's value goes to the other bank.
	always_ff @(posedge clk) begin
		if (state_q == S_DRAIN) begin
			len_mem[{~bank_q, u_q}] <= best_nxt;
		end
		len_rd_q <= len_mem[len_raddr];
	end

	// Relaxation step: the first round reads all lengths as zero.
	assign row_cur  = adj_vld_rd_q ? adj_rd_q : '0;
	assign cur_val  = (round_q == '0) ? '0 : len_rd_q;
	assign cand     = cur_val + LW'(1);
	assign best_nxt = (vld_s1 && row_cur[v_s1] && cand > best_q) ? cand : best_q;

	// Result formatting with the cap at n-1.
	assign cap_len    = (len_rd_q > LW'(n_m1)) ? n_m1 : len_rd_q[VW-1:0];
	assign out_vertex = dlp_pkg::VERTEX_W'(u_q) + dlp_pkg::VERTEX_W'(1);

	// Sequencer: loading, relaxation rounds and result emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			from_idx_q  <= '0;
			to_idx_q    <= '0;
			last_q      <= 1'b0;
			u_q         <= '0;
			v_q         <= '0;
			round_q     <= '0;
			bank_q      <= 1'b0;
			vld_s1      <= 1'b0;
			v_s1        <= '0;
			best_q      <= '0;
			cyc_q       <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tlast     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						from_idx_q <= VW'(in_from - dlp_pkg::VERTEX_W'(1));
						to_idx_q   <= VW'(in_to - dlp_pkg::VERTEX_W'(1));
						last_q     <= s_tlast;
						u_q        <= '0;
						round_q    <= '0;
						if (in_ok) begin
							state_q <= S_EDGE_WR;
						end else if (s_tlast) begin
							state_q <= S_ROW;
						end
					end
				end
				S_EDGE_WR: begin
					row_valid_q[from_idx_q] <= 1'b1;
					state_q <= last_q ? S_ROW : S_IDLE;
				end
				S_ROW: begin
					v_q     <= '0;
					vld_s1  <= 1'b0;
					best_q  <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					best_q <= best_nxt;
					vld_s1 <= 1'b1;
					v_s1   <= v_q;
					v_q    <= v_q + VW'(1);
					if (v_q == n_m1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					vld_s1 <= 1'b0;
					if (round_q == n_m1 && best_nxt > LW'(n_m1)) begin
						cyc_q <= 1'b1;
					end
					if (u_q == n_m1) begin
						u_q    <= '0;
						bank_q <= ~bank_q;
						if (round_q == n_m1) begin
							round_q <= '0;
							state_q <= S_EMIT_RD;
						end else begin
							round_q <= round_q + VW'(1);
							state_q <= S_ROW;
						end
					end else begin
						u_q     <= u_q + VW'(1);
						state_q <= S_ROW;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					m_tvalid <= 1'b1;
					m_tdata  <= {2'b00, cyc_q, dlp_pkg::PLEN_W'(cap_len), out_vertex};
					m_tlast  <= (u_q == n_m1);
					state_q  <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							row_valid_q <= '0;
							cyc_q       <= 1'b0;
							u_q         <= '0;
							state_q     <= S_IDLE;
						end else begin
							u_q     <= u_q + VW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the block's own sequencing.
	`DLP_ASSERT_IMPL(a_no_overlap, clk, arst_n, m_tvalid, !s_tready, "input open while a result waits")
	`DLP_ASSERT_IMPL(a_vertex_range, clk, arst_n, m_tvalid, (m_tdata[6:0] != 7'd0) && (m_tdata[6:0] <= n_eff), "result vertex out of range")
	`DLP_ASSERT_IMPL(a_last_is_n, clk, arst_n, m_tvalid && m_tlast, m_tdata[6:0] == n_eff, "final result is not vertex n")
	`DLP_ASSERT_NEXT(a_back_to_idle, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready && row_valid_q == '0, "block not idle after final result")

endmodule

`default_nettype wire

// File: dv/dlp_path_checker.sv
// Watcher that predicts longest-path results from the edge stream and checks the result stream.
`timescale 1ns / 1ps

module dlp_path_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dlp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [dlp_pkg::APB_DATA_W-1:0]     pwdata,
	input  logic                               pready,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [dlp_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                               s_tlast,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [dlp_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                               m_tlast,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 results_checked,
	output int                                 graphs_solved
);

	localparam int unsigned MAXV = 64;
	localparam int unsigned VW   = dlp_pkg::VERTEX_W;
	localparam int unsigned PW   = dlp_pkg::PLEN_W;

	// One vertex result as it should leave the block.
	typedef struct packed {
		logic [VW-1:0] vertex;
		logic [PW-1:0] plen;
		logic          cyc;
		logic          last;
	} path_result_t;

	logic [MAXV-1:0] adj_rows [MAXV];
	logic [VW-1:0]   vcount_reg;
	path_result_t    expected_paths[$];
	path_result_t    want;
	logic [VW-1:0]   edge_src;
	logic [VW-1:0]   edge_dst;
	int unsigned     n_now;
	int              fail_tally;
	int              result_tally;
	int              graph_tally;

	// The register value 0 acts as 1, and values above the maximum are clamped.
	function automatic int unsigned active_vertices(logic [VW-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAXV)
			return MAXV;
		return raw;
	endfunction

	// Synchronous relaxation over n rounds; values past n-1 mean a cycle and get capped.
	task automatic predict_longest_paths();
		int unsigned     n;
		logic [MAXV-1:0] used;
		logic [MAXV-1:0] row;
		byte unsigned    cur [MAXV];
		byte unsigned    nxt [MAXV];
		byte unsigned    best;
		logic            cyc;
		path_result_t    res;
		n = active_vertices(vcount_reg);
		used = (n >= MAXV) ? '1 : ((64'd1 << n) - 64'd1);
		for (int u = 0; u < MAXV; u++) begin
			cur[u] = 0;
			nxt[u] = 0;
		end
		for (int rnd = 0; rnd < n; rnd++) begin
			for (int u = 0; u < n; u++) begin
				row = adj_rows[u] & used;
				best = 0;
				for (int v = 0; v < n; v++) begin
					if (row[v] && (cur[v] + 1) > best)
						best = 8'(cur[v] + 1);
				end
				nxt[u] = best;
			end
			for (int u = 0; u < n; u++)
				cur[u] = nxt[u];
		end
		cyc = 1'b0;
		for (int u = 0; u < n; u++) begin
			if (cur[u] > n - 1)
				cyc = 1'b1;
		end
		for (int u = 0; u < n; u++) begin
			res.vertex = VW'(u + 1);
			res.plen   = PW'((cur[u] > n - 1) ? (n - 1) : cur[u]);
			res.cyc    = cyc;
			res.last   = (u + 1 == n);
			expected_paths.push_back(res);
		end
	endtask

	function automatic int field_mismatch(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val == act_val)
			return 0;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
		return 1;
	endfunction

	// All three channels are sampled at the rising edge, before the block updates them.
	always @(posedge clk) begin
		if (!arst_n) begin
			vcount_reg = dlp_pkg::VCOUNT_RESET;
			for (int u = 0; u < MAXV; u++)
				adj_rows[u] = '0;
			expected_paths.delete();
			fail_tally = 0;
			result_tally = 0;
			graph_tally = 0;
		end else begin
			// Register write on the access cycle.
			if (psel && penable && pwrite && pready &&
				paddr[dlp_pkg::APB_ADDR_W-1] == dlp_pkg::REG_VERTEX_COUNT)
				vcount_reg = pwdata[VW-1:0];

			// Result item: compare with the oldest expectation.
			if (m_tvalid && m_tready) begin
				if (expected_paths.size() == 0) begin
					$display("%0t: unexpected result, expected none, got vertex %0d length %0d",
						$time, m_tdata[VW-1:0], m_tdata[VW+PW-1:VW]);
					fail_tally++;
				end else begin
					want = expected_paths.pop_front();
					fail_tally += field_mismatch("vertex", want.vertex, m_tdata[VW-1:0]);
					fail_tally += field_mismatch("path_length", want.plen, m_tdata[VW+PW-1:VW]);
					fail_tally += field_mismatch("cycle_seen", want.cyc, m_tdata[VW+PW]);
					fail_tally += field_mismatch("last_result", want.last, m_tlast);
					result_tally++;
				end
			end

			// Edge item: endpoints are checked against the count in force on arrival.
			if (s_tvalid && s_tready) begin
				edge_src = s_tdata[VW-1:0];
				edge_dst = s_tdata[2*VW-1:VW];
				n_now = active_vertices(vcount_reg);
				if (edge_src >= 1 && edge_src <= n_now && edge_dst >= 1 && edge_dst <= n_now)
					adj_rows[edge_src-1][edge_dst-1] = 1'b1;
				if (s_tlast) begin
					predict_longest_paths();
					for (int u = 0; u < MAXV; u++)
						adj_rows[u] = '0;
					graph_tally++;
				end
			end
		end
		fail_count      <= fail_tally;
		pending         <= expected_paths.size();
		results_checked <= result_tally;
		graphs_solved   <= graph_tally;
	end

endmodule

// File: dv/dag_longest_path_per_vertex_core_test.sv
// Top of the longest-path testbench: clock, reset, edge and register stimulus, verdict.
`timescale 1ns / 1ps

module dag_longest_path_per_vertex_core_test;

	localparam int unsigned TOTAL_ITEMS = 370;
	localparam int unsigned LOAD_SETTLE = 8;
	localparam int unsigned END_SETTLE  = 40;
	localparam int unsigned LONG_HOLD   = 1500;
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam logic [dlp_pkg::APB_ADDR_W-1:0] VCOUNT_ADDR =
		{dlp_pkg::REG_VERTEX_COUNT, 2'b00};

	// Kinds of random graph.
	typedef enum int unsigned {
		SHAPE_DAG,
		SHAPE_CHAIN,
		SHAPE_CYCLIC,
		SHAPE_NOISE
	} graph_shape_e;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [dlp_pkg::APB_ADDR_W-1:0]    paddr = '0;
	logic [dlp_pkg::APB_DATA_W-1:0]    pwdata = '0;
	logic [dlp_pkg::APB_DATA_W-1:0]    prdata;
	logic                              pready;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	// Fields from bit 0: edge_from[6:0], edge_to[13:7], zero pad.
	logic [dlp_pkg::S_TDATA_W-1:0]     s_tdata = '0;
	logic                              s_tlast = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	// Fields from bit 0: vertex[6:0], path_length[12:7], cycle_seen[13], zero pad.
	logic [dlp_pkg::M_TDATA_W-1:0]     m_tdata;
	logic                              m_tlast;

	int          fail_count;
	int          pending;
	int          results_checked;
	int          graphs_solved;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned tx_burst = 0;
	int unsigned rx_burst = 0;
	logic [6:0]  vcount_now = dlp_pkg::VCOUNT_RESET;
	bit          hold_request = 1'b0;
	bit          hold_done = 1'b0;

	always #6 clk = ~clk;

	dag_longest_path_per_vertex_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	dlp_path_checker u_path_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.graphs_solved   (graphs_solved)
	);

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Idle cycles before the next item, with occasional back-to-back stretches.
	function automatic int unsigned draw_gap(inout int unsigned burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			burst_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic int unsigned active_vertices(logic [6:0] raw);
		if (raw == 0)
			return 1;
		if (raw > 64)
			return 64;
		return raw;
	endfunction

	// Returns {edge_to, edge_from} for a graph of the given shape over n vertices.
	function automatic logic [13:0] pick_edge(graph_shape_e shape, int unsigned n);
		int unsigned a;
		int unsigned b;
		a = $urandom_range(1, n);
		b = $urandom_range(1, n);
		if ($urandom_range(0, 15) == 0 || (shape == SHAPE_NOISE && $urandom_range(0, 1) == 0))
			return {7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
		case (shape)
			SHAPE_DAG: begin
				// Edges here only run upward, so they form no cycle among themselves.
				if (a < b)
					return {7'(b), 7'(a)};
				if (a > b)
					return {7'(a), 7'(b)};
				return {7'd0, 7'(a)};
			end
			SHAPE_CHAIN: begin
				a = (n > 1) ? $urandom_range(1, n - 1) : 1;
				return {7'(a + 1), 7'(a)};
			end
			default:
				return {7'(b), 7'(a)};
		endcase
	endfunction

	// Offers one edge item and returns at the edge where it is taken; tvalid stays high.
	task automatic send_edge(input logic [6:0] from_v, input logic [6:0] to_v, input logic last);
		int unsigned gap;
		gap = draw_gap(tx_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, to_v, from_v};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Stops offering, then waits for every expected result and for loading edges to settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	// Setup and access cycle; upper data bits are random and must be ignored.
	task automatic write_vertex_count(input logic [6:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= VCOUNT_ADDR;
		pwdata  <= ($urandom() & 32'hFFFF_FF80) | value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		vcount_now = value;
	endtask

	// Result side: random stalls, plus one long hold-off while edges keep coming.
	initial begin
		int unsigned gap;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				gap = draw_gap(rx_burst);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Edge and register stimulus, then the verdict.
	initial begin
		graph_shape_e shape;
		int unsigned  edge_total;
		int unsigned  n;
		int unsigned  pick;
		logic [13:0]  pair;
		bit           first_graph;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-size acyclic graph at the reset count, with a duplicate and dropped endpoints.
		send_edge(7'd1, 7'd2, 1'b0);
		send_edge(7'd2, 7'd3, 1'b0);
		send_edge(7'd3, 7'd64, 1'b0);
		send_edge(7'd64, 7'd63, 1'b0);
		send_edge(7'd1, 7'd2, 1'b0);
		send_edge(7'd65, 7'd1, 1'b0);
		send_edge(7'd0, 7'd5, 1'b0);
		send_edge(7'd127, 7'd127, 1'b0);
		send_edge(7'd10, 7'd64, 1'b1);
		drain_results();

		// Register above the maximum clamps to 64; a two-vertex cycle gets capped.
		write_vertex_count(7'd127);
		send_edge(7'd5, 7'd6, 1'b0);
		send_edge(7'd6, 7'd5, 1'b0);
		send_edge(7'd64, 7'd1, 1'b0);
		send_edge(7'd1, 7'd2, 1'b1);
		drain_results();

		// Count 0 acts as 1: a self loop is a cycle; the last mark rides a dropped edge.
		write_vertex_count(7'd0);
		send_edge(7'd1, 7'd1, 1'b0);
		send_edge(7'd2, 7'd1, 1'b1);
		drain_results();

		write_vertex_count(7'd1);
		send_edge(7'd1, 7'd2, 1'b1);
		drain_results();

		// Count lowered after loading: edges above the new count no longer count.
		write_vertex_count(7'd10);
		send_edge(7'd1, 7'd2, 1'b0);
		send_edge(7'd2, 7'd3, 1'b0);
		send_edge(7'd7, 7'd9, 1'b0);
		send_edge(7'd9, 7'd10, 1'b0);
		send_edge(7'd3, 7'd4, 1'b0);
		drain_results();
		write_vertex_count(7'd5);
		send_edge(7'd4, 7'd5, 1'b1);

		// Random graphs, mostly small so that relaxation stays short. The first one is
		// offered at once at the current count while the receiver holds back the results.
		hold_request = 1'b1;
		first_graph = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			if (!first_graph && $urandom_range(0, 3) == 0) begin
				drain_results();
				pick = $urandom_range(0, 15);
				if (pick == 0)
					write_vertex_count(7'd0);
				else if (pick <= 2)
					write_vertex_count(7'($urandom_range(9, 16)));
				else
					write_vertex_count(7'($urandom_range(1, 8)));
			end
			first_graph = 1'b0;
			shape = graph_shape_e'($urandom_range(0, 9) < 5 ? SHAPE_DAG :
				$urandom_range(0, 2) == 0 ? SHAPE_NOISE :
				$urandom_range(0, 1) == 0 ? SHAPE_CHAIN : SHAPE_CYCLIC);
			edge_total = $urandom_range(0, 12);
			for (int e = 0; e <= edge_total; e++) begin
				n = active_vertices(vcount_now);
				if (e > 0 && e == edge_total / 2 && n >= 2 && $urandom_range(0, 9) == 0) begin
					drain_results();
					write_vertex_count(7'($urandom_range(1, n - 1)));
					n = active_vertices(vcount_now);
				end
				pair = pick_edge(shape, n);
				send_edge(pair[6:0], pair[13:7], e == edge_total);
			end
		end

		drain_results();
		repeat (END_SETTLE) @(posedge clk);

		$display("Run summary: %0d edge items, %0d graphs, %0d vertex results in %0d cycles.",
			items_sent, graphs_solved, results_checked, cycle_count);
		$display("Covered vertex counts 0 to 127 in the register, cyclic and acyclic graphs, "
			, "dropped edges and a count lowered after loading.");
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
